[src/assert_macros.svh]
// Assertion helpers for the checker file crmsd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define CRMSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define CRMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/crmsd_pkg.sv]
`default_nettype none

package crmsd_pkg;

  localparam int COORD_W       = 18;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * COORD_W;
  localparam int SUM_W         = 52;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int RMSD_W        = 19;
  localparam int ATOMS_W       = 13;
  localparam int MAX_ATOMS_DEF = 4096;
  localparam int IN_DATA_W     = 112;
  localparam int OUT_DATA_W    = 40;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [RMSD_W-1:0] MAX_RMSD_RESET = RMSD_W'(256);

  // Register indexes, taken from paddr[2].
  localparam logic REG_MAX_RMSD = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_START,
    ST_ROOT,
    ST_LOAD
  } seq_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_SQRT
  } unit_state_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } unit_stat_t;

endpackage

`default_nettype wire

[src/crmsd_root_unit.sv]
`default_nettype none

// Mean and square root of the accumulated sum. One shared trial subtractor is
// used first for a restoring divide (one quotient bit per cycle), then for a
// digit-by-digit square root (one root bit per cycle).
module crmsd_root_unit #(
  parameter int CNT_W = 13
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [crmsd_pkg::SUM_W-1:0] sum,
  input  wire logic [CNT_W-1:0]            count,
  output crmsd_pkg::unit_stat_t            stat
);

  localparam int SUM_W  = crmsd_pkg::SUM_W;
  localparam int ROOT_W = crmsd_pkg::ROOT_W;
  localparam int REM_W  = (CNT_W + 1 > ROOT_W + 3) ? CNT_W + 1 : ROOT_W + 3;
  localparam int STEP_W = $clog2(SUM_W);

  crmsd_pkg::unit_state_t state_r, state_nxt;

  logic [REM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  dq_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;

  logic [REM_W-1:0] op_a, op_b;
  logic [REM_W:0]   trial;
  logic             ge;
  logic             last_step;
  logic             done;

  assign last_step = (step_r == '0);

  // Shared trial subtractor.
  always_comb begin
    if (state_r == crmsd_pkg::U_SQRT) begin
      op_a = {rem_r[REM_W-3:0], dq_r[SUM_W-1 -: 2]};
      op_b = REM_W'({root_r, 2'b01});
    end else begin
      op_a = {rem_r[REM_W-2:0], dq_r[SUM_W-1]};
      op_b = REM_W'(div_r);
    end
  end

  assign trial = {1'b0, op_a} - {1'b0, op_b};
  assign ge    = !trial[REM_W];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crmsd_pkg::U_IDLE: if (start) state_nxt = crmsd_pkg::U_DIV;
      crmsd_pkg::U_DIV:  if (last_step) state_nxt = crmsd_pkg::U_SQRT;
      crmsd_pkg::U_SQRT: if (last_step) state_nxt = crmsd_pkg::U_IDLE;
      default:           state_nxt = crmsd_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    unique case (state_r)
      crmsd_pkg::U_SQRT: done = last_step;
      default:           done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crmsd_pkg::U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      crmsd_pkg::U_IDLE: begin
        if (start) begin
          dq_r   <= sum;
          div_r  <= (count == '0) ? CNT_W'(1) : count;
          rem_r  <= '0;
          step_r <= STEP_W'(SUM_W - 1);
        end
      end
      crmsd_pkg::U_DIV: begin
        rem_r <= ge ? trial[REM_W-1:0] : op_a;
        dq_r  <= {dq_r[SUM_W-2:0], ge};
        if (last_step) begin
          rem_r  <= '0;
          root_r <= '0;
          step_r <= STEP_W'(ROOT_W - 1);
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
      crmsd_pkg::U_SQRT: begin
        rem_r  <= ge ? trial[REM_W-1:0] : op_a;
        dq_r   <= {dq_r[SUM_W-3:0], 2'b00};
        root_r <= {root_r[ROOT_W-2:0], ge};
        step_r <= step_r - STEP_W'(1);
      end
      default: ;
    endcase
  end

  assign stat.done = done;
  assign stat.root = root_r;

endmodule

`default_nettype wire

[src/coordinate_rmsd_accumulator_core.sv]
`default_nettype none

// Root mean square deviation of two structures, streamed one atom per beat.
// The in_ channel carries an atom: six signed 18-bit coordinates in in_tdata
// and in_tlast on the final atom of a structure pair. The out_ channel gives
// one result beat per pair: rmsd, the inclusive limit flag, the atom count
// (saturated at MAX_ATOMS) and the count overflow flag.
// The limit max_rmsd is written over the APB-style cfg_ port at byte address 0.
// An atom passes through ST_MUL once per axis and then ST_ADD: one multiplier
// squares the x, y and z differences in turn and one saturating adder folds
// them into the sum, so in_tready stays low until the atom is done.
// An atom that arrives once the count is saturated only sets the overflow flag
// and skips the multiplier and adder. After the last atom, the shared divide
// and root unit forms the mean and then its square root, and the result is
// loaded into the output register once that register is free.
// The result sits in an output register, so a stalled receiver does not block
// the next run of atoms; only the following result waits until it is taken.
// Reset clears the sum, count, overflow flag and output valid flag, and sets
// max_rmsd to 256 (one angstrom).
module coordinate_rmsd_accumulator_core #(
  parameter int MAX_ATOMS = crmsd_pkg::MAX_ATOMS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata, lowest bits first: x_first, y_first, z_first,
  // x_second, y_second, z_second (18 bits each), zero fill.
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [crmsd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                             in_tlast,
  // out_tdata, lowest bits first: rmsd (19), within_limit (1),
  // atoms_seen (13), count_overflow (1), zero fill.
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [crmsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [crmsd_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [crmsd_pkg::CFG_DW-1:0]     cfg_pwdata,
  output      logic [crmsd_pkg::CFG_DW-1:0]     cfg_prdata,
  output      logic                             cfg_pready
);

  localparam int COORD_W = crmsd_pkg::COORD_W;
  localparam int DIFF_W  = crmsd_pkg::DIFF_W;
  localparam int SQ_W    = crmsd_pkg::SQ_W;
  localparam int SUM_W   = crmsd_pkg::SUM_W;
  localparam int ROOT_W  = crmsd_pkg::ROOT_W;
  localparam int RMSD_W  = crmsd_pkg::RMSD_W;
  localparam int ATOMS_W = crmsd_pkg::ATOMS_W;
  localparam int CNT_W   = $clog2(MAX_ATOMS + 1);

  // ---------------------------------------------------------------------
  // Configuration register. The write lands on the access beat.
  // ---------------------------------------------------------------------
  logic [RMSD_W-1:0] max_rmsd_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == crmsd_pkg::REG_MAX_RMSD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rmsd_r <= crmsd_pkg::MAX_RMSD_RESET;
    end else if (cfg_wr) begin
      max_rmsd_r <= cfg_pwdata[RMSD_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == crmsd_pkg::REG_MAX_RMSD) begin
      cfg_prdata = crmsd_pkg::CFG_DW'(max_rmsd_r);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  crmsd_pkg::seq_state_t state_r, state_nxt;
  crmsd_pkg::unit_stat_t unit_stat;

  logic [1:0]         idx_r;
  logic               last_r;
  logic [COORD_W-1:0] first_r  [3];
  logic [COORD_W-1:0] second_r [3];
  logic [SQ_W-1:0]    product_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   count_r;
  logic               overflow_r;

  logic in_acc;
  logic full;
  logic out_free;
  logic mul_en, add_en, unit_start, load_en;

  assign in_acc   = in_tvalid && in_tready;
  assign full     = (count_r == CNT_W'(MAX_ATOMS));
  assign out_free = !out_tvalid || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crmsd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (!full) begin
            state_nxt = crmsd_pkg::ST_MUL;
          end else if (in_tlast) begin
            state_nxt = crmsd_pkg::ST_START;
          end
        end
      end
      crmsd_pkg::ST_MUL:   if (idx_r == 2'd2) state_nxt = crmsd_pkg::ST_ADD;
      crmsd_pkg::ST_ADD:   state_nxt = last_r ? crmsd_pkg::ST_START : crmsd_pkg::ST_IDLE;
      crmsd_pkg::ST_START: state_nxt = crmsd_pkg::ST_ROOT;
      crmsd_pkg::ST_ROOT:  if (unit_stat.done) state_nxt = crmsd_pkg::ST_LOAD;
      crmsd_pkg::ST_LOAD:  if (out_free) state_nxt = crmsd_pkg::ST_IDLE;
      default:             state_nxt = crmsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    mul_en     = 1'b0;
    add_en     = 1'b0;
    unit_start = 1'b0;
    load_en    = 1'b0;
    unique case (state_r)
      crmsd_pkg::ST_IDLE:  in_tready = 1'b1;
      crmsd_pkg::ST_MUL: begin
        mul_en = 1'b1;
        add_en = (idx_r != 2'd0);
      end
      crmsd_pkg::ST_ADD:   add_en = 1'b1;
      crmsd_pkg::ST_START: unit_start = 1'b1;
      crmsd_pkg::ST_ROOT:  ;
      crmsd_pkg::ST_LOAD:  load_en = out_free;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crmsd_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_en) begin
        idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  // Atom capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r <= in_tlast;
      for (int i = 0; i < 3; i++) begin
        first_r[i]  <= in_tdata[i*COORD_W +: COORD_W];
        second_r[i] <= in_tdata[(i+3)*COORD_W +: COORD_W];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared multiplier: one axis per cycle, product registered before the add.
  // ---------------------------------------------------------------------
  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] square;

  assign diff   = DIFF_W'($signed(first_r[idx_r])) - DIFF_W'($signed(second_r[idx_r]));
  assign square = diff * diff;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      product_r <= square[SQ_W-1:0];
    end
  end

  // Saturating accumulate. Once the sum sticks at its maximum it stays there,
  // so adding axis by axis saturates exactly like adding the atom at once.
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;

  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(product_r);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (load_en) begin
      sum_r      <= '0;
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      if (add_en) begin
        sum_r <= sum_sat;
      end
      if (state_r == crmsd_pkg::ST_ADD) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (in_acc && full) begin
        overflow_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divide and root unit.
  // ---------------------------------------------------------------------
  crmsd_root_unit #(
    .CNT_W (CNT_W)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .sum   (sum_r),
    .count (count_r),
    .stat  (unit_stat)
  );

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic                       out_valid_r;
  logic [RMSD_W-1:0]          rmsd_r;
  logic                       within_r;
  logic [ATOMS_W-1:0]         atoms_r;
  logic                       oflow_out_r;
  logic [ATOMS_W+CNT_W-1:0]   count_ext;
  logic                       in_limit;

  assign count_ext = {{ATOMS_W{1'b0}}, count_r};
  assign in_limit  = (unit_stat.root <= ROOT_W'(max_rmsd_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      rmsd_r      <= unit_stat.root[RMSD_W-1:0];
      within_r    <= in_limit;
      atoms_r     <= count_ext[ATOMS_W-1:0];
      oflow_out_r <= overflow_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = crmsd_pkg::OUT_DATA_W'({oflow_out_r, atoms_r, within_r, rmsd_r});

endmodule

`default_nettype wire

[src/crmsd_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module crmsd_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             in_tlast,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [crmsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                             cfg_pready
);

  // A stalled result beat keeps its value.
  `CRMSD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // The last atom of a run always keeps the block busy on the next cycle.
  `CRMSD_ASSERT(a_last_busy, clk, rst_n, in_tvalid && in_tready && in_tlast |=> !in_tready, "ready right after last atom")

  // No result survives reset.
  `CRMSD_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // The configuration port never inserts wait states.
  `CRMSD_ASSERT(a_pready, clk, rst_n, cfg_pready, "cfg_pready low")

endmodule

bind coordinate_rmsd_accumulator_core crmsd_checker u_crmsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

// Bench for the streaming RMSD core. The driver sends atom beats from a
// queue that the stimulus process fills, and the monitors fold every
// accepted atom into a software copy of the accumulator. Every result beat
// is checked field by field against the oldest predicted pair result.
module tb;

  localparam int COORD_W    = crmsd_pkg::COORD_W;
  localparam int RMSD_W     = crmsd_pkg::RMSD_W;
  localparam int ATOMS_W    = crmsd_pkg::ATOMS_W;
  localparam int IN_DATA_W  = crmsd_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = crmsd_pkg::OUT_DATA_W;
  localparam int CFG_AW     = crmsd_pkg::CFG_AW;
  localparam int CFG_DW     = crmsd_pkg::CFG_DW;
  localparam int MAX_ATOMS_DEF = crmsd_pkg::MAX_ATOMS_DEF;
  localparam logic              REG_MAX_RMSD   = crmsd_pkg::REG_MAX_RMSD;
  localparam logic [RMSD_W-1:0] MAX_RMSD_RESET = crmsd_pkg::MAX_RMSD_RESET;

  localparam int          CYCLE_LIMIT   = 2_000_000;
  localparam int          SETTLE_CYCLES = 100;
  localparam logic [51:0] SUM_CEILING   = '1;

  // Byte addresses on the configuration port. The register index sits in paddr[2].
  localparam logic [CFG_AW-1:0] ADDR_MAX_RMSD = {REG_MAX_RMSD, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_NO_REG   = {~REG_MAX_RMSD, 2'b00};

  typedef struct packed {
    logic                      last;
    logic signed [COORD_W-1:0] zs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] zf;
    logic signed [COORD_W-1:0] yf;
    logic signed [COORD_W-1:0] xf;
  } atom_t;

  typedef struct packed {
    logic [RMSD_W-1:0]  rmsd;
    logic               in_limit;
    logic [ATOMS_W-1:0] atoms;
    logic               ovf;
  } pair_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  coordinate_rmsd_accumulator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Atoms waiting to be sent, and pair results that the block still owes.
  atom_t        pending_atoms[$];
  pair_result_t pair_results_due[$];

  // Shadow of the accumulator state and of the limit register.
  logic [51:0]       shadow_sum;
  int                shadow_count;
  logic              shadow_ovf;
  logic [RMSD_W-1:0] shadow_limit;

  // When steady is set, neither side of the stream inserts idle cycles.
  logic steady = 1'b0;
  logic atom_taken = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;

  int cycle_count = 0;
  int error_count = 0;
  int atoms_fed = 0;
  int pairs_checked = 0;
  int within_hits = 0;
  int limit_settings = 0;

  pair_result_t got, want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // A run that hangs or drops a result ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint unsigned sq_gap(input logic signed [COORD_W-1:0] p,
                                             input logic signed [COORD_W-1:0] q);
    longint d;
    d = longint'(p) - longint'(q);
    return longint'(d * d);
  endfunction

  // Floor of the square root, one result bit per pass, two input bits at a time.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Folds one accepted atom into the shadow sum. Once MAX_ATOMS atoms are in,
  // further atoms only mark the overflow. The last atom closes the pair.
  task automatic fold_atom(input atom_t a);
    longint unsigned add;
    longint unsigned mean;
    longint unsigned root;
    pair_result_t    r;
    if (shadow_count >= MAX_ATOMS_DEF) begin
      shadow_ovf = 1'b1;
    end else begin
      add = sq_gap(a.xf, a.xs) + sq_gap(a.yf, a.ys) + sq_gap(a.zf, a.zs);
      if (64'(shadow_sum) > 64'(SUM_CEILING) - add) shadow_sum = SUM_CEILING;
      else shadow_sum = shadow_sum + 52'(add);
      shadow_count++;
    end
    if (a.last) begin
      mean       = 64'(shadow_sum) / longint'((shadow_count != 0) ? shadow_count : 1);
      root       = int_sqrt(mean);
      r.rmsd     = root[RMSD_W-1:0];
      r.in_limit = (root <= 64'(shadow_limit));
      r.atoms    = shadow_count[ATOMS_W-1:0];
      r.ovf      = shadow_ovf;
      pair_results_due.push_back(r);
      shadow_sum   = '0;
      shadow_count = 0;
      shadow_ovf   = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic atom_t mk_atom(input int xf, input int yf, input int zf,
                                    input int xs, input int ys, input int zs,
                                    input logic last);
    atom_t a;
    a.xf   = xf[COORD_W-1:0];
    a.yf   = yf[COORD_W-1:0];
    a.zf   = zf[COORD_W-1:0];
    a.xs   = xs[COORD_W-1:0];
    a.ys   = ys[COORD_W-1:0];
    a.zs   = zs[COORD_W-1:0];
    a.last = last;
    return a;
  endfunction

  // Second coordinate sits within 2^scale of the first, so the spread of the
  // run (and with it the rmsd) follows scale. Now and then it is unrelated.
  function automatic logic [COORD_W-1:0] partner(input logic [COORD_W-1:0] first, input int scale);
    logic [COORD_W-1:0] delta;
    if ($urandom_range(0, 7) == 0) return COORD_W'($urandom);
    delta = COORD_W'($urandom_range(0, 1 << scale));
    return ($urandom_range(0, 1) != 0) ? first - delta : first + delta;
  endfunction

  function automatic atom_t rand_atom(input int scale, input logic last);
    atom_t a;
    a.xf   = COORD_W'($urandom);
    a.yf   = COORD_W'($urandom);
    a.zf   = COORD_W'($urandom);
    a.xs   = partner(a.xf, scale);
    a.ys   = partner(a.yf, scale);
    a.zs   = partner(a.zf, scale);
    a.last = last;
    return a;
  endfunction

  task automatic queue_pair(input int n);
    int scale;
    scale = $urandom_range(0, COORD_W - 1);
    for (int i = 0; i < n; i++) pending_atoms.push_back(rand_atom(scale, i == n - 1));
  endtask

  // Mostly short structure pairs with a few longer ones; a stray atom carrying
  // tlast on its own gives a one-atom pair.
  task automatic queue_random_pairs(input int atom_target);
    int n;
    int queued;
    queued = 0;
    while (queued < atom_target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      queue_pair(n);
      queued += n;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  // Holds off until the driver is empty and every predicted result has been
  // checked, then lets the divide and root unit settle before any register write.
  task automatic drain();
    while (pending_atoms.size() != 0 || in_tvalid || pair_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr[2] == REG_MAX_RMSD) begin
      shadow_limit = data[RMSD_W-1:0];
      limit_settings++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Reads the limit register back and compares it with the shadow copy.
  task automatic cfg_check_limit();
    @(negedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr  <= ADDR_MAX_RMSD;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(shadow_limit)) begin
      $error("max_rmsd readback mismatch: expected %0d, got %0d", shadow_limit, cfg_prdata);
      error_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver and receiver, both changing their outputs on the falling edge
  // ---------------------------------------------------------------------------

  // A beat stays on the bus until the rising edge that takes it; the next one
  // follows after a random gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !atom_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_atoms.size() != 0) begin
        atom_t a;
        a = pending_atoms.pop_front();
        in_tdata  <= {4'b0000, a.zs, a.ys, a.xs, a.zf, a.yf, a.xf};
        in_tlast  <= a.last;
        in_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The receiver mostly takes results at once but sometimes stalls for more
  // than a whole divide and root pass.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      case ($urandom_range(0, 9))
        0, 1: recv_stall = $urandom_range(1, 4);
        2: recv_stall = $urandom_range(20, 120);
        default: recv_stall = 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitors, sampling on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    atom_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      atoms_fed++;
      fold_atom({in_tlast, in_tdata[107:0]});
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.rmsd     = out_tdata[18:0];
      got.in_limit = out_tdata[19];
      got.atoms    = out_tdata[32:20];
      got.ovf      = out_tdata[33];
      if (pair_results_due.size() == 0) begin
        $error("result beat with no pair result expected: rmsd %0d, atoms %0d",
               got.rmsd, got.atoms);
        error_count++;
      end else begin
        want = pair_results_due.pop_front();
        pairs_checked++;
        if (want.in_limit) within_hits++;
        if (got.rmsd !== want.rmsd) begin
          $error("rmsd mismatch: expected %0d, got %0d", want.rmsd, got.rmsd);
          error_count++;
        end
        if (got.in_limit !== want.in_limit) begin
          $error("within_limit mismatch: expected %0d, got %0d", want.in_limit, got.in_limit);
          error_count++;
        end
        if (got.atoms !== want.atoms) begin
          $error("atoms_seen mismatch: expected %0d, got %0d", want.atoms, got.atoms);
          error_count++;
        end
        if (got.ovf !== want.ovf) begin
          $error("count_overflow mismatch: expected %0d, got %0d", want.ovf, got.ovf);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    shadow_sum   = '0;
    shadow_count = 0;
    shadow_ovf   = 1'b0;
    shadow_limit = MAX_RMSD_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the limit, then the directed atoms under it.
    cfg_check_limit();
    // Identical structures give zero deviation.
    pending_atoms.push_back(mk_atom(0, 0, 0, 0, 0, 0, 1'b1));
    // Widest possible spread, both ways round.
    pending_atoms.push_back(mk_atom(-131072, -131072, -131072, 131071, 131071, 131071, 1'b1));
    pending_atoms.push_back(mk_atom(131071, 131071, 131071, -131072, -131072, -131072, 1'b1));
    // Each axis alone at its extremes, within one three-atom pair.
    pending_atoms.push_back(mk_atom(-131072, 0, 0, 131071, 0, 0, 1'b0));
    pending_atoms.push_back(mk_atom(0, 131071, 0, 0, -131072, 0, 1'b0));
    pending_atoms.push_back(mk_atom(0, 0, -131072, 0, 0, 131071, 1'b1));
    // rmsd exactly at the one-angstrom limit passes, one step above fails.
    pending_atoms.push_back(mk_atom(256, 0, 0, 0, 0, 0, 1'b1));
    pending_atoms.push_back(mk_atom(0, -257, 0, 0, 0, 0, 1'b1));
    // The mean is floored before the root: sum 2 over 2 atoms, then 3 over 2.
    pending_atoms.push_back(mk_atom(1, 0, 0, 0, 0, 0, 1'b0));
    pending_atoms.push_back(mk_atom(0, 0, 1, 0, 0, 0, 1'b1));
    pending_atoms.push_back(mk_atom(1, 1, 0, 0, 0, 0, 1'b0));
    pending_atoms.push_back(mk_atom(0, 0, 0, 0, 0, -1, 1'b1));
    // Equal coordinates away from zero, and a one-bit deviation.
    pending_atoms.push_back(mk_atom(-5000, 77777, -1, -5000, 77777, -1, 1'b0));
    pending_atoms.push_back(mk_atom(65536, -65536, 3, 65536, -65536, 2, 1'b1));
    drain();

    // Limit extremes, including bits above the register width, and a write to
    // an index that holds no register, which must leave the limit alone.
    cfg_write(ADDR_MAX_RMSD, '0);
    cfg_check_limit();
    queue_random_pairs(150);
    drain();

    cfg_write(ADDR_MAX_RMSD, '1);
    cfg_write(ADDR_NO_REG, 32'h0000_0005);
    cfg_check_limit();
    queue_random_pairs(150);
    drain();

    cfg_write(ADDR_MAX_RMSD, 32'd454040);
    cfg_check_limit();
    queue_random_pairs(150);
    drain();

    // Random limits, spread over the orders of magnitude that rmsd takes.
    for (int p = 0; p < 8; p++) begin
      cfg_write(ADDR_MAX_RMSD, $urandom >> $urandom_range(13, 31));
      cfg_check_limit();
      steady = (p == 3);
      queue_random_pairs(150);
      drain();
      // Once the sender waits for every result before the next pair.
      if (p == 5) begin
        for (int k = 0; k < 12; k++) begin
          queue_pair($urandom_range(1, 8));
          drain();
        end
      end
    end
    steady = 1'b0;

    // A last group of pairs under a mid-range limit.
    cfg_write(ADDR_MAX_RMSD, 32'd4000);
    queue_random_pairs(40);
    drain();

    $display("Fed %0d atoms in %0d checked pairs, short and long, with random idling.",
             atoms_fed, pairs_checked);
    $display("Used %0d max_rmsd settings; %0d pairs fell within the limit.",
             limit_settings + 1, within_hits);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
